// ===== hw/rtl/lfss_pkg.sv =====
package lfss_pkg;

    // map limits and field widths
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int SIDE_W   = 11;
    localparam int POS_W    = 10;
    localparam int COL_AW   = $clog2(MAX_COLS);

    // queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'b1;

    // one classified cell, front to back
    typedef struct packed {
        logic              cell_free;
        logic [COL_AW-1:0] col;
        logic [POS_W-1:0]  row;
        logic              edge_cell;    // first row or first column
        logic              frame_start;  // first cell of the map
        logic              col_wrap;     // last cell of a row
        logic              row_wrap;     // last cell of the map
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [SIDE_W-1:0] square_here;
        logic [SIDE_W-1:0] best_size;
        logic [POS_W-1:0]  best_row;
        logic [POS_W-1:0]  best_col;
        logic              frame_done;
    } result_t;

endpackage

// ===== hw/rtl/lfss_front.sv =====
module lfss_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lfss_pkg::SIDE_W-1:0] map_cols,
    input  logic [lfss_pkg::SIDE_W-1:0] map_rows,
    input  logic                        push,
    input  logic                        cell_free,
    output logic                        full,
    input  logic                        cmd_pop,
    output logic                        cmd_empty,
    output lfss_pkg::cmd_t              cmd_head
);
    import lfss_pkg::*;

    localparam int CQ_AW = $clog2(CMDQ_DEPTH);
    localparam int CQ_CW = $clog2(CMDQ_DEPTH + 1);

    // zero acts as one, oversize clamps to the maximum
    function automatic logic [SIDE_W-1:0] bound_dim(
        input logic [SIDE_W-1:0] v,
        input logic [SIDE_W-1:0] top
    );
        logic [SIDE_W-1:0] r;
        begin
            if (v == '0)
                r = SIDE_W'(1);
            else if (v > top)
                r = top;
            else
                r = v;
            return r;
        end
    endfunction

    logic [COL_AW-1:0] col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0] cols_eff, rows_eff;
    logic              accept;
    cmd_t              cmd_new;

    cmd_t              cq_mem [CMDQ_DEPTH];
    logic [CQ_AW-1:0]  cq_wr_reg, cq_rd_reg;
    logic [CQ_CW-1:0]  cq_count_reg;

    assign cols_eff = bound_dim(map_cols, SIDE_W'(MAX_COLS));
    assign rows_eff = bound_dim(map_rows, SIDE_W'(MAX_ROWS));

    assign full      = (cq_count_reg == CQ_CW'(CMDQ_DEPTH));
    assign cmd_empty = (cq_count_reg == '0);
    assign accept    = push && !full;
    assign cmd_head  = cq_mem[cq_rd_reg];

    always_comb
    begin
        cmd_new.cell_free   = cell_free;
        cmd_new.col         = col_reg;
        cmd_new.row         = row_reg;
        cmd_new.edge_cell   = (col_reg == '0) || (row_reg == '0);
        cmd_new.frame_start = (col_reg == '0) && (row_reg == '0);
        cmd_new.col_wrap    = ((SIDE_W'(col_reg) + SIDE_W'(1)) >= cols_eff);
        cmd_new.row_wrap    = cmd_new.col_wrap
                              && ((SIDE_W'(row_reg) + SIDE_W'(1)) >= rows_eff);
        col_next = cmd_new.col_wrap ? '0 : col_reg + COL_AW'(1);
        if (!cmd_new.col_wrap)
            row_next = row_reg;
        else if (cmd_new.row_wrap)
            row_next = '0;
        else
            row_next = row_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            cq_wr_reg    <= '0;
            cq_rd_reg    <= '0;
            cq_count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                cq_wr_reg <= cq_wr_reg + CQ_AW'(1);
            end
            if (cmd_pop)
                cq_rd_reg <= cq_rd_reg + CQ_AW'(1);
            if (accept && !cmd_pop)
                cq_count_reg <= cq_count_reg + CQ_CW'(1);
            else if (!accept && cmd_pop)
                cq_count_reg <= cq_count_reg - CQ_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cq_mem[cq_wr_reg] <= cmd_new;
    end

endmodule

// ===== hw/rtl/lfss_back.sv =====
module lfss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_empty,
    input  lfss_pkg::cmd_t              cmd_head,
    output logic                        cmd_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [lfss_pkg::SIDE_W-1:0] square_here,
    output logic [lfss_pkg::SIDE_W-1:0] best_size,
    output logic [lfss_pkg::POS_W-1:0]  best_row,
    output logic [lfss_pkg::POS_W-1:0]  best_col,
    output logic                        frame_done
);
    import lfss_pkg::*;

    localparam int OQ_AW = $clog2(OUTQ_DEPTH);
    localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

    // line store, one read and one write per cycle
    logic [SIDE_W-1:0] line_mem [MAX_COLS];

    // compute stage
    logic              s_valid_reg;
    cmd_t              s_reg;
    logic [SIDE_W-1:0] up_rd_reg;
    logic              byp_hit_reg;
    logic [SIDE_W-1:0] byp_val_reg;

    logic [SIDE_W-1:0] left_reg, diag_reg;
    logic [SIDE_W-1:0] best_side_reg, best_side_next;
    logic [POS_W-1:0]  best_row_reg, best_row_next;
    logic [POS_W-1:0]  best_col_reg, best_col_next;

    logic [SIDE_W-1:0] up, min_lu, min_all, side;
    result_t           res;

    // output queue
    result_t           oq_mem [OUTQ_DEPTH];
    logic [OQ_AW-1:0]  oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0]  oq_count_reg;
    logic              oq_pop;
    result_t           oq_head;

    // issue only when the result has a guaranteed slot
    assign cmd_pop = !cmd_empty
                     && ((oq_count_reg + OQ_CW'(s_valid_reg)) < OQ_CW'(OUTQ_DEPTH));

    always_comb
    begin
        up      = byp_hit_reg ? byp_val_reg : up_rd_reg;
        min_lu  = (left_reg < up) ? left_reg : up;
        min_all = (diag_reg < min_lu) ? diag_reg : min_lu;
        if (s_reg.edge_cell)
            side = SIDE_W'(s_reg.cell_free);
        else if (s_reg.cell_free)
            side = (min_all == '1) ? min_all : min_all + SIDE_W'(1);
        else
            side = '0;

        best_side_next = best_side_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (s_reg.frame_start)
        begin
            best_side_next = side;
            best_row_next  = '0;
            best_col_next  = '0;
        end
        else if (side > best_side_reg)
        begin
            best_side_next = side;
            best_row_next  = s_reg.row;
            best_col_next  = POS_W'(s_reg.col);
        end

        res.square_here = side;
        res.best_size   = best_side_next;
        res.best_row    = best_row_next;
        res.best_col    = best_col_next;
        res.frame_done  = s_reg.row_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            oq_wr_reg     <= '0;
            oq_rd_reg     <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            s_valid_reg <= cmd_pop;
            if (s_valid_reg)
            begin
                left_reg      <= s_reg.col_wrap ? '0 : side;
                diag_reg      <= s_reg.col_wrap ? '0 : up;
                best_side_reg <= best_side_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
                oq_wr_reg     <= oq_wr_reg + OQ_AW'(1);
            end
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_AW'(1);
            if (s_valid_reg && !oq_pop)
                oq_count_reg <= oq_count_reg + OQ_CW'(1);
            else if (!s_valid_reg && oq_pop)
                oq_count_reg <= oq_count_reg - OQ_CW'(1);
        end
    end

    // payload: line store, read data, write-to-read bypass, output queue
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s_reg       <= cmd_head;
            up_rd_reg   <= line_mem[cmd_head.col];
            byp_hit_reg <= s_valid_reg && (s_reg.col == cmd_head.col);
            byp_val_reg <= side;
        end
        if (s_valid_reg)
        begin
            line_mem[s_reg.col] <= side;
            oq_mem[oq_wr_reg]   <= res;
        end
    end

    assign empty   = (oq_count_reg == '0);
    assign oq_pop  = pop && !empty;
    assign oq_head = oq_mem[oq_rd_reg];

    assign square_here = oq_head.square_here;
    assign best_size   = oq_head.best_size;
    assign best_row    = oq_head.best_row;
    assign best_col    = oq_head.best_col;
    assign frame_done  = oq_head.frame_done;

endmodule

// ===== hw/rtl/largest_free_square_scan_top.sv =====
// Largest free square scan: cells of a binary map arrive in raster order, one
// free bit per item, and each yields one result item with the side of the
// largest all-free square whose bottom-right corner is that cell, the largest
// side so far in the frame and its corner (earliest cell wins a tie), and a
// done flag on the map's last cell. Sustained rate is one item per clock while
// pop keeps up; that figure is set by the line store (one read and one write
// per cell) and by the loop through the left neighbor's side. A cell's result
// shows with empty low after the item queue and the compute stage. The front
// counts position and classifies each cell into a four-entry queue; the back
// reads the previous row from the line store, does the min-plus-one update and
// feeds a four-entry result queue, so push keeps going while a result waits on
// pop. map_cols and map_rows (index 0 and 1) are written through the cfg port;
// the user must write them only while the block is idle; the block does not
// enforce it. Zero acts as one and values above 1024 act as 1024. The line
// store needs no clearing after reset: the first row never uses what it reads.
module largest_free_square_scan_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // cell input
    input  logic                           push,
    output logic                           full,
    input  logic                           cell_free,
    // results
    output logic                           empty,
    input  logic                           pop,
    output logic [lfss_pkg::SIDE_W-1:0]    square_here,
    output logic [lfss_pkg::SIDE_W-1:0]    best_size,
    output logic [lfss_pkg::POS_W-1:0]     best_row,
    output logic [lfss_pkg::POS_W-1:0]     best_col,
    output logic                           frame_done,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfss_pkg::SIDE_W-1:0]    cfg_data
);
    import lfss_pkg::*;

    logic [SIDE_W-1:0] map_cols_reg;
    logic [SIDE_W-1:0] map_rows_reg;
    logic              cmd_empty;
    logic              cmd_pop;
    cmd_t              cmd_head;

    // registers always take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cols_reg <= SIDE_W'(MAX_COLS);
            map_rows_reg <= SIDE_W'(MAX_ROWS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_COLS: map_cols_reg <= cfg_data;
                REG_MAP_ROWS: map_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: position counters, cell classification, item queue
    lfss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_cols  (map_cols_reg),
        .map_rows  (map_rows_reg),
        .push      (push),
        .cell_free (cell_free),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head)
    );

    // back: line store, square update, best tracking, result queue
    lfss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd_head    (cmd_head),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .square_here (square_here),
        .best_size   (best_size),
        .best_row    (best_row),
        .best_col    (best_col),
        .frame_done  (frame_done)
    );

`ifndef SYNTHESIS
    // the best so far always covers the current cell's square
    a_best_covers_here: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (best_size >= square_here))
        else $error("best_size below square_here");

    // no best square means the corner still sits at the origin
    a_no_best_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && best_size == '0) |-> (best_row == '0 && best_col == '0))
        else $error("corner set without a best square");

    // a square can never be wider than the map allows
    a_side_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (square_here <= SIDE_W'(MAX_COLS)))
        else $error("square side out of range");
`endif

endmodule
